/* rtl/avr_pkg.sv */
package avr_pkg;

    // Default datapath parameters.
    localparam int COORD_WIDTH_DEF    = 32;
    localparam int TRIG_FRAC_BITS_DEF = 14;

    // Fixed register widths.
    localparam int PIVOT_W    = 32;
    localparam int TRIG_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SIN     = 3'd7;

    // Request opcodes.
    localparam logic OP_POINT     = 1'b0;
    localparam logic OP_DIRECTION = 1'b1;

    // Rotation setup as seen by the datapath.
    typedef struct packed {
        logic signed [PIVOT_W-1:0] pivot_x;
        logic signed [PIVOT_W-1:0] pivot_y;
        logic signed [PIVOT_W-1:0] pivot_z;
        logic signed [TRIG_W-1:0]  axis_x;
        logic signed [TRIG_W-1:0]  axis_y;
        logic signed [TRIG_W-1:0]  axis_z;
        logic signed [TRIG_W-1:0]  cos_a;
        logic signed [TRIG_W-1:0]  sin_a;
    } t_cfg;

    // Reset setup: unit x axis, zero angle, pivot at the origin.
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;

    localparam t_cfg CFG_RESET = '{
        pivot_x: '0,
        pivot_y: '0,
        pivot_z: '0,
        axis_x:  TRIG_ONE,
        axis_y:  '0,
        axis_z:  '0,
        cos_a:   TRIG_ONE,
        sin_a:   '0
    };

endpackage

/* rtl/avr_vec_if.sv */
interface avr_vec_if #(
    parameter int COORD_WIDTH = avr_pkg::COORD_WIDTH_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;

    modport source (output valid, opcode, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, opcode, coord_x, coord_y, coord_z, output ready);

endinterface

/* rtl/avr_rot_if.sv */
interface avr_rot_if #(
    parameter int COORD_WIDTH = avr_pkg::COORD_WIDTH_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] rot_x;
    logic signed [COORD_WIDTH-1:0] rot_y;
    logic signed [COORD_WIDTH-1:0] rot_z;
    logic                          saturated;

    modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, saturated, output ready);

endinterface

/* rtl/avr_cfg_regs.sv */
module avr_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [avr_pkg::CFG_IDX_W-1:0]    i_idx,
    input  logic [avr_pkg::CFG_DATA_W-1:0]   i_data,
    output avr_pkg::t_cfg                    o_cfg
);
    import avr_pkg::*;

    t_cfg r_cfg;

    // Register file; each write lands in the addressed field only.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_we) begin
            unique case (i_idx)
                REG_PIVOT_X: r_cfg.pivot_x <= i_data[PIVOT_W-1:0];
                REG_PIVOT_Y: r_cfg.pivot_y <= i_data[PIVOT_W-1:0];
                REG_PIVOT_Z: r_cfg.pivot_z <= i_data[PIVOT_W-1:0];
                REG_AXIS_X:  r_cfg.axis_x  <= i_data[TRIG_W-1:0];
                REG_AXIS_Y:  r_cfg.axis_y  <= i_data[TRIG_W-1:0];
                REG_AXIS_Z:  r_cfg.axis_z  <= i_data[TRIG_W-1:0];
                REG_COS:     r_cfg.cos_a   <= i_data[TRIG_W-1:0];
                REG_SIN:     r_cfg.sin_a   <= i_data[TRIG_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

`ifndef SYNTHESIS
    // A sine write shows up on the next cycle and leaves the cosine alone.
    a_sin_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_we && i_idx == REG_SIN |=>
            r_cfg.sin_a == $past(i_data[TRIG_W-1:0]) && $stable(r_cfg.cos_a))
        else $error("sine register write not applied as expected");
`endif

endmodule

/* rtl/avr_front.sv */
module avr_front #(
    parameter int COORD_WIDTH    = avr_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = avr_pkg::TRIG_FRAC_BITS_DEF,
    localparam int DW   = ((COORD_WIDTH > avr_pkg::PIVOT_W) ? COORD_WIDTH
                                                            : avr_pkg::PIVOT_W) + 1,
    localparam int PW   = DW + avr_pkg::TRIG_W,
    localparam int DOTW = PW + 3 - TRIG_FRAC_BITS,
    localparam int QW   = PW + 2 - TRIG_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  avr_pkg::t_cfg                 i_cfg,
    input  logic                          i_vld,
    output logic                          o_rdy,
    input  logic                          i_opcode,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    output logic                          o_vld,
    input  logic                          i_rdy,
    output logic                          o_pt,
    output logic signed [DOTW-1:0]        o_dot,
    output logic signed [QW-1:0]          o_q  [3],
    output logic signed [PW-1:0]          o_dc [3]
);
    import avr_pkg::*;

    localparam int NS   = 3;
    localparam int SUMW = PW + 2;
    localparam int CRW  = PW + 1;

    localparam logic signed [SUMW:0] DOT_HALF = (SUMW + 1)'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [CRW:0]  CR_HALF  = (CRW + 1)'(1) <<< (TRIG_FRAC_BITS - 1);

    // Stage valid bits and the ready chain that lets bubbles collapse.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_vin;
    logic [NS:0]   w_rdy;

    assign w_vin = {r_vld[NS-2:0], i_vld};

    always_comb begin
        w_rdy[NS] = i_rdy;
        for (int i = NS - 1; i >= 0; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
        for (int i = 0; i < NS; i++) begin
            n_vld[i] = w_rdy[i] ? w_vin[i] : r_vld[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage 1: offset the vector by the pivot for point requests.
    logic signed [DW-1:0] w_coord [3];
    logic signed [DW-1:0] w_piv   [3];
    logic signed [DW-1:0] n_d     [3];
    logic signed [DW-1:0] r1_d    [3];
    logic                 r1_pt;

    always_comb begin
        w_coord[0] = DW'(i_coord_x);
        w_coord[1] = DW'(i_coord_y);
        w_coord[2] = DW'(i_coord_z);
        w_piv[0]   = DW'(i_cfg.pivot_x);
        w_piv[1]   = DW'(i_cfg.pivot_y);
        w_piv[2]   = DW'(i_cfg.pivot_z);
        for (int j = 0; j < 3; j++) begin
            n_d[j] = (i_opcode == OP_POINT) ? w_coord[j] - w_piv[j] : w_coord[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_d  <= n_d;
            r1_pt <= (i_opcode == OP_POINT);
        end
    end

    // Stage 2: all axis-by-vector products and the cosine terms.
    logic signed [TRIG_W-1:0] w_k [3];
    logic signed [PW-1:0]     r2_kd [3][3];
    logic signed [PW-1:0]     r2_dc [3];
    logic                     r2_pt;

    assign w_k[0] = i_cfg.axis_x;
    assign w_k[1] = i_cfg.axis_y;
    assign w_k[2] = i_cfg.axis_z;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r2_kd[i][j] <= PW'(w_k[i]) * PW'(r1_d[j]);
                end
                r2_dc[i] <= PW'(r1_d[i]) * PW'(i_cfg.cos_a);
            end
            r2_pt <= r1_pt;
        end
    end

    // Stage 3: dot product and cross product, both rounded half up.
    logic signed [SUMW-1:0] n_sum;
    logic signed [SUMW:0]   n_sumh;
    logic signed [CRW-1:0]  n_cr  [3];
    logic signed [CRW:0]    n_crh [3];
    logic signed [DOTW-1:0] r3_dot;
    logic signed [QW-1:0]   r3_q  [3];
    logic signed [PW-1:0]   r3_dc [3];
    logic                   r3_pt;

    always_comb begin
        n_sum  = SUMW'(r2_kd[0][0]) + SUMW'(r2_kd[1][1]) + SUMW'(r2_kd[2][2]);
        n_sumh = (SUMW + 1)'(n_sum) + DOT_HALF;
        n_cr[0] = CRW'(r2_kd[1][2]) - CRW'(r2_kd[2][1]);
        n_cr[1] = CRW'(r2_kd[2][0]) - CRW'(r2_kd[0][2]);
        n_cr[2] = CRW'(r2_kd[0][1]) - CRW'(r2_kd[1][0]);
        for (int i = 0; i < 3; i++) begin
            n_crh[i] = (CRW + 1)'(n_cr[i]) + CR_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r3_dot <= DOTW'(n_sumh >>> TRIG_FRAC_BITS);
            for (int i = 0; i < 3; i++) begin
                r3_q[i] <= QW'(n_crh[i] >>> TRIG_FRAC_BITS);
            end
            r3_dc <= r2_dc;
            r3_pt <= r2_pt;
        end
    end

    assign o_rdy = w_rdy[0];
    assign o_vld = r_vld[NS-1];
    assign o_pt  = r3_pt;
    assign o_dot = r3_dot;
    assign o_q   = r3_q;
    assign o_dc  = r3_dc;

`ifndef SYNTHESIS
    // An item in the first stage that may move on is present one stage later.
    a_front_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && w_rdy[1] |=> r_vld[1])
        else $error("front pipeline dropped an item between stages");
`endif

endmodule

/* rtl/avr_back.sv */
module avr_back #(
    parameter int COORD_WIDTH    = avr_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = avr_pkg::TRIG_FRAC_BITS_DEF,
    localparam int DW   = ((COORD_WIDTH > avr_pkg::PIVOT_W) ? COORD_WIDTH
                                                            : avr_pkg::PIVOT_W) + 1,
    localparam int PW   = DW + avr_pkg::TRIG_W,
    localparam int DOTW = PW + 3 - TRIG_FRAC_BITS,
    localparam int QW   = PW + 2 - TRIG_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  avr_pkg::t_cfg                 i_cfg,
    input  logic                          i_vld,
    output logic                          o_rdy,
    input  logic                          i_pt,
    input  logic signed [DOTW-1:0]        i_dot,
    input  logic signed [QW-1:0]          i_q  [3],
    input  logic signed [PW-1:0]          i_dc [3],
    output logic                          o_vld,
    input  logic                          i_rdy,
    output logic signed [COORD_WIDTH-1:0] o_rot_x,
    output logic signed [COORD_WIDTH-1:0] o_rot_y,
    output logic signed [COORD_WIDTH-1:0] o_rot_z,
    output logic                          o_sat
);
    import avr_pkg::*;

    localparam int NS  = 5;
    localparam int DCW = DOTW + TRIG_W;
    localparam int RCW = DCW + 1 - TRIG_FRAC_BITS;
    localparam int WW  = ((DOTW > RCW) ? DOTW : RCW) + 1;
    localparam int WKW = WW + TRIG_W;
    localparam int QSW = QW + TRIG_W;
    localparam int M1  = (PW > WKW) ? PW : WKW;
    localparam int AW  = ((M1 > QSW) ? M1 : QSW) + 2;
    localparam int RW  = AW + 1 - TRIG_FRAC_BITS;
    localparam int SW  = ((RW > PIVOT_W) ? RW : PIVOT_W) + 1;

    localparam logic signed [DCW:0] RC_HALF = (DCW + 1)'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [AW:0]  AC_HALF = (AW + 1)'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] LIM    = SW'(1) <<< (COORD_WIDTH - 1);
    localparam logic signed [SW-1:0] HI     = LIM - SW'(1);
    localparam logic signed [SW-1:0] LO     = -LIM;
    localparam logic signed [COORD_WIDTH-1:0] OUT_MAX = COORD_WIDTH'(HI);
    localparam logic signed [COORD_WIDTH-1:0] OUT_MIN = COORD_WIDTH'(LO);

    // Stage valid bits and ready chain; the last stage is the output register.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_vin;
    logic [NS:0]   w_rdy;

    assign w_vin = {r_vld[NS-2:0], i_vld};

    always_comb begin
        w_rdy[NS] = i_rdy;
        for (int i = NS - 1; i >= 0; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
        for (int i = 0; i < NS; i++) begin
            n_vld[i] = w_rdy[i] ? w_vin[i] : r_vld[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage 4: scale the dot product by the cosine.
    logic signed [DCW-1:0]  r4_dotc;
    logic signed [DOTW-1:0] r4_dot;
    logic signed [QW-1:0]   r4_q  [3];
    logic signed [PW-1:0]   r4_dc [3];
    logic                   r4_pt;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r4_dotc <= DCW'(i_dot) * DCW'(i_cfg.cos_a);
            r4_dot  <= i_dot;
            r4_q    <= i_q;
            r4_dc   <= i_dc;
            r4_pt   <= i_pt;
        end
    end

    // Stage 5: w = dot * (1 - cos), formed as dot minus the rounded product.
    logic signed [DCW:0]   n_rch;
    logic signed [RCW-1:0] n_rc;
    logic signed [WW-1:0]  r5_w;
    logic signed [QW-1:0]  r5_q  [3];
    logic signed [PW-1:0]  r5_dc [3];
    logic                  r5_pt;

    always_comb begin
        n_rch = (DCW + 1)'(r4_dotc) + RC_HALF;
        n_rc  = RCW'(n_rch >>> TRIG_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r5_w  <= WW'(r4_dot) - WW'(n_rc);
            r5_q  <= r4_q;
            r5_dc <= r4_dc;
            r5_pt <= r4_pt;
        end
    end

    // Stage 6: axis and sine terms.
    logic signed [TRIG_W-1:0] w_k [3];
    logic signed [WKW-1:0]    r6_wk [3];
    logic signed [QSW-1:0]    r6_qs [3];
    logic signed [PW-1:0]     r6_dc [3];
    logic                     r6_pt;

    assign w_k[0] = i_cfg.axis_x;
    assign w_k[1] = i_cfg.axis_y;
    assign w_k[2] = i_cfg.axis_z;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                r6_wk[i] <= WKW'(r5_w) * WKW'(w_k[i]);
                r6_qs[i] <= QSW'(r5_q[i]) * QSW'(i_cfg.sin_a);
            end
            r6_dc <= r5_dc;
            r6_pt <= r5_pt;
        end
    end

    // Stage 7: sum the three terms and round back to coordinate scale.
    logic signed [AW:0]   n_acch [3];
    logic signed [RW-1:0] r7_r   [3];
    logic                 r7_pt;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_acch[i] = (AW + 1)'(AW'(r6_dc[i]) + AW'(r6_wk[i]) + AW'(r6_qs[i])) + AC_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            for (int i = 0; i < 3; i++) begin
                r7_r[i] <= RW'(n_acch[i] >>> TRIG_FRAC_BITS);
            end
            r7_pt <= r6_pt;
        end
    end

    // Stage 8: restore the pivot for points, then clip to the output range.
    logic signed [SW-1:0]          w_piv [3];
    logic signed [SW-1:0]          n_sum [3];
    logic signed [COORD_WIDTH-1:0] n_rot [3];
    logic [2:0]                    n_clip;
    logic signed [COORD_WIDTH-1:0] r_rot [3];
    logic                          r_sat;

    always_comb begin
        w_piv[0] = SW'(i_cfg.pivot_x);
        w_piv[1] = SW'(i_cfg.pivot_y);
        w_piv[2] = SW'(i_cfg.pivot_z);
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = r7_pt ? SW'(r7_r[i]) + w_piv[i] : SW'(r7_r[i]);
            priority if (n_sum[i] > HI) begin
                n_rot[i]  = OUT_MAX;
                n_clip[i] = 1'b1;
            end else if (n_sum[i] < LO) begin
                n_rot[i]  = OUT_MIN;
                n_clip[i] = 1'b1;
            end else begin
                n_rot[i]  = COORD_WIDTH'(n_sum[i]);
                n_clip[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_rot <= n_rot;
            r_sat <= |n_clip;
        end
    end

    assign o_rdy   = w_rdy[0];
    assign o_vld   = r_vld[NS-1];
    assign o_rot_x = r_rot[0];
    assign o_rot_y = r_rot[1];
    assign o_rot_z = r_rot[2];
    assign o_sat   = r_sat;

`ifndef SYNTHESIS
    // A flagged result carries at least one component pinned at a limit.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] && r_sat |->
            r_rot[0] == OUT_MAX || r_rot[0] == OUT_MIN ||
            r_rot[1] == OUT_MAX || r_rot[1] == OUT_MIN ||
            r_rot[2] == OUT_MAX || r_rot[2] == OUT_MIN)
        else $error("saturation flag set without a clipped component");

    // The w stage hands an item on to the product stage when it may move.
    a_back_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] && w_rdy[2] |=> r_vld[2])
        else $error("back pipeline dropped an item between stages");
`endif

endmodule

/* rtl/axis_angle_vector_rotation.sv */
// Axis-angle vector rotation, r = v*cos + (k.v)(1-cos)k + (k x v)*sin.
//
// Requests arrive on i_vec: opcode 0 rotates a point about the axis through
// the pivot, opcode 1 rotates a direction vector about the origin. Results
// leave on o_rot as Q16.16 components, clipped to the signed coordinate
// range, with saturated set when any component was clipped.
// Axis, pivot, cosine and sine are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user does so only while no request is in flight, which
// the block does not enforce. The axis is used as given: use unit length.
//
// The datapath is an 8-stage pipeline: pivot offset, products, dot/cross,
// cosine scale, (1-cos) term, axis/sine products, sum and round, pivot add
// and clip. A request accepted at i_vec passes through these stage registers
// in that order before it shows on o_rot, and one request per cycle is
// accepted for as long as o_rot.ready stays high.
// When the receiver stalls, each full stage holds its data; empty stages
// keep filling, so i_vec.ready only drops once all eight stages are full.
// Reset empties the pipeline and returns the setup to a unit x axis, zero
// angle and a pivot at the origin.
module axis_angle_vector_rotation #(
    parameter int COORD_WIDTH    = avr_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = avr_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [avr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [avr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    avr_vec_if.sink                         i_vec,
    avr_rot_if.source                       o_rot
);
    import avr_pkg::*;

    localparam int DW   = ((COORD_WIDTH > PIVOT_W) ? COORD_WIDTH : PIVOT_W) + 1;
    localparam int PW   = DW + TRIG_W;
    localparam int DOTW = PW + 3 - TRIG_FRAC_BITS;
    localparam int QW   = PW + 2 - TRIG_FRAC_BITS;

    t_cfg                          w_cfg;
    logic                          w_in_rdy;
    logic                          w_mid_vld;
    logic                          w_mid_rdy;
    logic                          w_mid_pt;
    logic signed [DOTW-1:0]        w_mid_dot;
    logic signed [QW-1:0]          w_mid_q  [3];
    logic signed [PW-1:0]          w_mid_dc [3];
    logic                          w_out_vld;
    logic signed [COORD_WIDTH-1:0] w_rot_x;
    logic signed [COORD_WIDTH-1:0] w_rot_y;
    logic signed [COORD_WIDTH-1:0] w_rot_z;
    logic                          w_sat;

    // Rotation setup registers.
    avr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // Pivot offset, products, dot and cross products.
    avr_front #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_vld     (i_vec.valid),
        .o_rdy     (w_in_rdy),
        .i_opcode  (i_vec.opcode),
        .i_coord_x (i_vec.coord_x),
        .i_coord_y (i_vec.coord_y),
        .i_coord_z (i_vec.coord_z),
        .o_vld     (w_mid_vld),
        .i_rdy     (w_mid_rdy),
        .o_pt      (w_mid_pt),
        .o_dot     (w_mid_dot),
        .o_q       (w_mid_q),
        .o_dc      (w_mid_dc)
    );

    // Remaining Rodrigues terms, pivot restore and clipping.
    avr_back #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_vld   (w_mid_vld),
        .o_rdy   (w_mid_rdy),
        .i_pt    (w_mid_pt),
        .i_dot   (w_mid_dot),
        .i_q     (w_mid_q),
        .i_dc    (w_mid_dc),
        .o_vld   (w_out_vld),
        .i_rdy   (o_rot.ready),
        .o_rot_x (w_rot_x),
        .o_rot_y (w_rot_y),
        .o_rot_z (w_rot_z),
        .o_sat   (w_sat)
    );

    assign i_vec.ready     = w_in_rdy;
    assign o_rot.valid     = w_out_vld;
    assign o_rot.rot_x     = w_rot_x;
    assign o_rot.rot_y     = w_rot_y;
    assign o_rot.rot_z     = w_rot_z;
    assign o_rot.saturated = w_sat;

endmodule

/* tb/tb_axis_angle_vector_rotation.sv */
`timescale 1ns / 1ps

module tb_axis_angle_vector_rotation;

    import avr_pkg::*;

    localparam int COORD_W     = COORD_WIDTH_DEF;
    localparam int FRAC        = TRIG_FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 140;
    localparam int PHASES      = 10;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam int ONE_Q16 = 65536;

    typedef struct packed {
        logic signed [COORD_W-1:0] rot_x;
        logic signed [COORD_W-1:0] rot_y;
        logic signed [COORD_W-1:0] rot_z;
        logic                      saturated;
    } t_rotation;

    // Keeps a copy of the rotation setup, predicts every accepted request
    // and compares the results in order.
    class rotation_scoreboard;
        logic signed [PIVOT_W-1:0] pivot [3];
        logic signed [TRIG_W-1:0]  axis [3];
        logic signed [TRIG_W-1:0]  cos_a;
        logic signed [TRIG_W-1:0]  sin_a;
        t_rotation                 pending_rotations [$];
        int                        mismatches;
        int                        results_seen;

        function new();
            pivot[0]     = CFG_RESET.pivot_x;
            pivot[1]     = CFG_RESET.pivot_y;
            pivot[2]     = CFG_RESET.pivot_z;
            axis[0]      = CFG_RESET.axis_x;
            axis[1]      = CFG_RESET.axis_y;
            axis[2]      = CFG_RESET.axis_z;
            cos_a        = CFG_RESET.cos_a;
            sin_a        = CFG_RESET.sin_a;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // Mirrors one write on the configuration port.
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PIVOT_X: pivot[0] = data[PIVOT_W-1:0];
                REG_PIVOT_Y: pivot[1] = data[PIVOT_W-1:0];
                REG_PIVOT_Z: pivot[2] = data[PIVOT_W-1:0];
                REG_AXIS_X:  axis[0]  = data[TRIG_W-1:0];
                REG_AXIS_Y:  axis[1]  = data[TRIG_W-1:0];
                REG_AXIS_Z:  axis[2]  = data[TRIG_W-1:0];
                REG_COS:     cos_a    = data[TRIG_W-1:0];
                REG_SIN:     sin_a    = data[TRIG_W-1:0];
                default: ;
            endcase
        endfunction

        // Round half up and drop the trig fraction bits.
        function longint round_trig(longint v);
            return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        endfunction

        // Rodrigues rotation in exact integers, then clipping to the coordinate range.
        function t_rotation predict_rotation(logic op, logic signed [COORD_W-1:0] cx,
                                             logic signed [COORD_W-1:0] cy,
                                             logic signed [COORD_W-1:0] cz);
            longint                    d [3];
            longint                    k [3];
            longint                    q [3];
            longint                    r, c, s, dot, w, hi, lo;
            logic signed [COORD_W-1:0] comp [3];
            t_rotation                 res;
            int                        i;
            hi = (longint'(1) <<< (COORD_W - 1)) - 1;
            lo = -hi - 1;
            d[0] = cx;
            d[1] = cy;
            d[2] = cz;
            res.saturated = 1'b0;
            for (i = 0; i < 3; i++) begin
                k[i] = axis[i];
                if (op == OP_POINT) begin
                    d[i] = d[i] - pivot[i];
                end
            end
            c = cos_a;
            s = sin_a;
            dot  = round_trig(k[0] * d[0] + k[1] * d[1] + k[2] * d[2]);
            w    = dot - round_trig(dot * c);
            q[0] = round_trig(k[1] * d[2] - k[2] * d[1]);
            q[1] = round_trig(k[2] * d[0] - k[0] * d[2]);
            q[2] = round_trig(k[0] * d[1] - k[1] * d[0]);
            for (i = 0; i < 3; i++) begin
                r = round_trig(d[i] * c + w * k[i] + q[i] * s);
                if (op == OP_POINT) begin
                    r = r + pivot[i];
                end
                if (r > hi) begin
                    r = hi;
                    res.saturated = 1'b1;
                end else if (r < lo) begin
                    r = lo;
                    res.saturated = 1'b1;
                end
                comp[i] = r[COORD_W-1:0];
            end
            res.rot_x = comp[0];
            res.rot_y = comp[1];
            res.rot_z = comp[2];
            return res;
        endfunction

        function void note_request(logic op, logic signed [COORD_W-1:0] cx,
                                   logic signed [COORD_W-1:0] cy,
                                   logic signed [COORD_W-1:0] cz);
            pending_rotations.push_back(predict_rotation(op, cx, cy, cz));
        endfunction

        function int pending_count();
            return pending_rotations.size();
        endfunction

        // Prints one line per mismatch and counts every one.
        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(t_rotation got);
            t_rotation want;
            if (pending_rotations.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no request waiting",
                                          results_seen));
            end else begin
                want = pending_rotations.pop_front();
                if (got.rot_x !== want.rot_x) begin
                    report_mismatch($sformatf("result %0d rot_x got %h want %h",
                                              results_seen, got.rot_x, want.rot_x));
                end
                if (got.rot_y !== want.rot_y) begin
                    report_mismatch($sformatf("result %0d rot_y got %h want %h",
                                              results_seen, got.rot_y, want.rot_y));
                end
                if (got.rot_z !== want.rot_z) begin
                    report_mismatch($sformatf("result %0d rot_z got %h want %h",
                                              results_seen, got.rot_z, want.rot_z));
                end
                if (got.saturated !== want.saturated) begin
                    report_mismatch($sformatf("result %0d saturated got %b want %b",
                                              results_seen, got.saturated, want.saturated));
                end
            end
            results_seen++;
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [CFG_DATA_W-1:0] setup_words [8];
    int unsigned           cycle_count = 0;
    rotation_scoreboard    sb = new();
    t_rotation             got_rotation;

    avr_vec_if #(.COORD_WIDTH(COORD_W)) vec_ch ();
    avr_rot_if #(.COORD_WIDTH(COORD_W)) rot_ch ();

    axis_angle_vector_rotation #(
        .COORD_WIDTH    (COORD_W),
        .TRIG_FRAC_BITS (FRAC)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_vec      (vec_ch),
        .o_rot      (rot_ch)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit in case the block stops answering.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Note every accepted request.
    always @(posedge clk) begin
        if (rst_n && vec_ch.valid && vec_ch.ready) begin
            sb.note_request(vec_ch.opcode, vec_ch.coord_x, vec_ch.coord_y, vec_ch.coord_z);
        end
    end

    // Check every accepted result.
    always @(posedge clk) begin
        if (rst_n && rot_ch.valid === 1'b1 && rot_ch.ready) begin
            got_rotation.rot_x     = rot_ch.rot_x;
            got_rotation.rot_y     = rot_ch.rot_y;
            got_rotation.rot_z     = rot_ch.rot_z;
            got_rotation.saturated = rot_ch.saturated;
            sb.check_result(got_rotation);
        end
    end

    // The receiver switches between stall patterns from window to window:
    // always ready, mostly ready, long stall bursts and coin flips.
    initial begin
        int mode;
        int window;
        int hold;
        mode   = 0;
        window = 0;
        hold   = 0;
        rot_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (window == 0) begin
                mode   = $urandom_range(0, 3);
                window = $urandom_range(50, 300);
            end
            window--;
            case (mode)
                0: rot_ch.ready = 1'b1;
                1: rot_ch.ready = ($urandom_range(0, 3) != 0);
                2: begin
                    if (hold == 0) begin
                        rot_ch.ready = ~rot_ch.ready;
                        hold = rot_ch.ready ? $urandom_range(1, 10) : $urandom_range(1, 20);
                    end
                    hold--;
                end
                default: rot_ch.ready = $urandom_range(0, 1);
            endcase
        end
    end

    // Drives one request and holds it until the block takes it.
    task automatic send_request(logic op, logic signed [COORD_W-1:0] cx,
                                logic signed [COORD_W-1:0] cy,
                                logic signed [COORD_W-1:0] cz);
        @(negedge clk);
        vec_ch.valid   = 1'b1;
        vec_ch.opcode  = op;
        vec_ch.coord_x = cx;
        vec_ch.coord_y = cy;
        vec_ch.coord_z = cz;
        @(posedge clk);
        while (!vec_ch.ready) @(posedge clk);
    endtask

    task automatic idle_gap(int cycles);
        @(negedge clk);
        vec_ch.valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Stops sending and waits until every predicted result has come back,
    // then lets the pipeline run dry.
    task automatic wait_for_results();
        @(negedge clk);
        vec_ch.valid = 1'b0;
        while (sb.pending_count() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Loads a full rotation setup once the block is idle. The trig registers
    // sometimes carry junk in the unused upper data bits.
    task automatic load_setup(int px, int py, int pz, int ax, int ay, int az, int c, int s);
        int          i;
        logic [31:0] junk;
        wait_for_results();
        setup_words[REG_PIVOT_X] = px;
        setup_words[REG_PIVOT_Y] = py;
        setup_words[REG_PIVOT_Z] = pz;
        setup_words[REG_AXIS_X]  = ax;
        setup_words[REG_AXIS_Y]  = ay;
        setup_words[REG_AXIS_Z]  = az;
        setup_words[REG_COS]     = c;
        setup_words[REG_SIN]     = s;
        for (i = 0; i < 8; i++) begin
            junk = $urandom;
            if ($urandom_range(0, 1) == 0) begin
                junk = '0;
            end
            @(negedge clk);
            cfg_we  = 1'b1;
            cfg_idx = CFG_IDX_W'(i);
            if (cfg_idx <= REG_PIVOT_Z) begin
                cfg_data = setup_words[i];
            end else begin
                cfg_data = {junk[31:TRIG_W], setup_words[i][TRIG_W-1:0]};
            end
            sb.set_register(cfg_idx, cfg_data);
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Coordinates: full range, small and medium values, the extremes and whole multiples of ONE_Q16.
    function automatic logic signed [COORD_W-1:0] random_coord();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom_range(0, 1 << 21) - (1 << 20);
            7:          return int'($urandom) >>> 6;
            8: begin
                case ($urandom_range(0, 5))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return '0;
                    3:       return -1;
                    4:       return ONE_Q16;
                    default: return -ONE_Q16;
                endcase
            end
            default:    return (int'($urandom_range(0, 255)) - 128) * ONE_Q16;
        endcase
    endfunction

    // Picks a rotation setup of the given kind: random unit axis with a small
    // or full range pivot, quarter turns about a coordinate axis, raw register
    // bits, and a zero axis.
    task automatic random_setup(int kind);
        real ux, uy, uz, norm, ang;
        int  ax, ay, az, c, s, px, py, pz, quad, sel, sgn;
        ux   = $itor($urandom_range(0, 2000)) - 1000.0;
        uy   = $itor($urandom_range(0, 2000)) - 1000.0;
        uz   = $itor($urandom_range(0, 2000)) - 1000.0;
        norm = $sqrt(ux * ux + uy * uy + uz * uz);
        if (norm < 1.0) begin
            ux   = 1.0;
            norm = 1.0;
        end
        ang = $itor($urandom_range(0, 62831)) / 10000.0;
        ax  = $rtoi(16384.0 * ux / norm);
        ay  = $rtoi(16384.0 * uy / norm);
        az  = $rtoi(16384.0 * uz / norm);
        c   = $rtoi(16384.0 * $cos(ang));
        s   = $rtoi(16384.0 * $sin(ang));
        px  = random_coord();
        py  = random_coord();
        pz  = random_coord();
        case (kind)
            0: begin
                px = int'($urandom_range(0, 1 << 25)) - (1 << 24);
                py = int'($urandom_range(0, 1 << 25)) - (1 << 24);
                pz = int'($urandom_range(0, 1 << 25)) - (1 << 24);
            end
            1: begin
                px = $urandom;
                py = $urandom;
                pz = $urandom;
            end
            2: begin
                quad = $urandom_range(0, 3);
                sel  = $urandom_range(0, 2);
                sgn  = $urandom_range(0, 1) ? int'(TRIG_ONE) : -int'(TRIG_ONE);
                ax   = (sel == 0) ? sgn : 0;
                ay   = (sel == 1) ? sgn : 0;
                az   = (sel == 2) ? sgn : 0;
                c    = (quad == 0) ? int'(TRIG_ONE) : (quad == 2) ? -int'(TRIG_ONE) : 0;
                s    = (quad == 1) ? int'(TRIG_ONE) : (quad == 3) ? -int'(TRIG_ONE) : 0;
            end
            3: begin
                px = $urandom;
                py = $urandom;
                pz = $urandom;
                ax = $urandom;
                ay = $urandom;
                az = $urandom;
                c  = $urandom;
                s  = $urandom;
            end
            default: begin
                ax = 0;
                ay = 0;
                az = 0;
                c  = int'($urandom_range(0, 32768)) - 16384;
                s  = int'($urandom_range(0, 32768)) - 16384;
            end
        endcase
        load_setup(px, py, pz, ax, ay, az, c, s);
    endtask

    initial begin
        int  ph;
        int  sent;
        int  burst;
        int  j;
        logic op;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        vec_ch.valid   = 1'b0;
        vec_ch.opcode  = OP_POINT;
        vec_ch.coord_x = '0;
        vec_ch.coord_y = '0;
        vec_ch.coord_z = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset setup: identity rotation, both request kinds, extreme coordinates.
        send_request(OP_POINT, '0, '0, '0);
        send_request(OP_DIRECTION, COORD_MAX, COORD_MIN, -1);
        send_request(OP_POINT, COORD_MIN, COORD_MAX, 1);

        // Quarter turn about z through an offset pivot, with clipping on both ends.
        load_setup(32'sh0001_8000, -32'sh0002_0000, 32'sh0000_4000,
                   0, 0, TRIG_ONE, 0, TRIG_ONE);
        send_request(OP_POINT, 32'sh0003_0000, -32'sh0002_0000, 32'sh0000_4000);
        send_request(OP_DIRECTION, ONE_Q16, '0, '0);
        send_request(OP_POINT, COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(OP_DIRECTION, COORD_MIN, COORD_MIN, COORD_MIN);
        send_request(OP_POINT, COORD_MIN, '0, COORD_MAX);

        // Zero axis with cosine -1: the result is the negated vector.
        load_setup(0, 0, 0, 0, 0, 0, -int'(TRIG_ONE), TRIG_ONE);
        send_request(OP_DIRECTION, ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16);
        send_request(OP_DIRECTION, COORD_MIN, COORD_MAX, '0);
        send_request(OP_POINT, -ONE_Q16, 12345, COORD_MIN);

        // Register values beyond the nominal range, taken as their signed bits.
        load_setup(COORD_MAX, COORD_MIN, 0, 32767, -32768, 32767, -32768, 32767);
        send_request(OP_POINT, '0, '0, '0);
        send_request(OP_DIRECTION, ONE_Q16, -ONE_Q16, 1);
        send_request(OP_POINT, COORD_MAX, COORD_MIN, -1);
        send_request(OP_DIRECTION, 1, 1, 1);

        // Axis that is not of unit length.
        load_setup(ONE_Q16, 0, -ONE_Q16, TRIG_ONE, TRIG_ONE, TRIG_ONE, 8192, 14189);
        send_request(OP_POINT, 5 * ONE_Q16, -7 * ONE_Q16, 11 * ONE_Q16);
        send_request(OP_DIRECTION, -3 * ONE_Q16, 32'sh0000_8001, 2 * ONE_Q16);

        // Random phases: bursts of requests with random gaps, and now and then
        // a pause until every result is back.
        for (ph = 0; ph < PHASES; ph++) begin
            random_setup(ph % 5);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 30);
                for (j = 0; j < burst && sent < PHASE_ITEMS; j++) begin
                    op = $urandom_range(0, 1) ? OP_DIRECTION : OP_POINT;
                    send_request(op, random_coord(), random_coord(), random_coord());
                    sent++;
                end
                if ($urandom_range(0, 49) == 0) begin
                    wait_for_results();
                end else if ($urandom_range(0, 3) != 0) begin
                    idle_gap($urandom_range(1, 8));
                end
            end
        end

        wait_for_results();
        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
